// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is held
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must hold at every clock edge out of reset
`define CHK_ALWAYS(label, expr, msg) \
    `CHK_ASSERT(label, (expr), msg)

`endif

// File: rtl/erm_pkg.sv
package erm_pkg;

    // Window and derived widths
    localparam int WINDOW = 5;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    // Field widths
    localparam int WIDTH_W = 16;
    localparam int DIST_W  = 15;
    localparam int KEY_W   = DIST_W + 1;

    // Distance scale: (width * 281) >> 10 gives 1/16 cm units
    localparam int SCALE_W = 9;
    localparam logic [SCALE_W-1:0] DIST_SCALE = SCALE_W'(281);
    localparam int DIST_SHIFT = 10;
    localparam int PROD_W = WIDTH_W + SCALE_W;

    // Sort key of an invalid reading: above every valid distance
    localparam logic [KEY_W-1:0] KEY_INVALID = {1'b1, {DIST_W{1'b0}}};

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 1'b1;
    localparam logic [DIST_W-1:0] MIN_RANGE_RST = DIST_W'(32);
    localparam logic [DIST_W-1:0] MAX_RANGE_RST = DIST_W'(6400);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WRITE,
        ST_RD_CAND,
        ST_LD_CAND,
        ST_CMP,
        ST_DONE
    } state_t;

    // Control of the rank accumulator
    typedef struct packed {
        logic clear;
        logic step;
    } rank_ctl_t;

endpackage

// File: rtl/erm_ram.sv
module erm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/erm_rank.sv
module erm_rank (
    input  logic                      clk,
    input  logic                      rst_n,
    input  erm_pkg::rank_ctl_t        ctl,
    input  logic [erm_pkg::KEY_W-1:0] key_j,
    input  logic [erm_pkg::KEY_W-1:0] cand,
    input  logic [erm_pkg::SLOT_W-1:0] idx_j,
    input  logic [erm_pkg::SLOT_W-1:0] idx_i,
    output logic [erm_pkg::CNT_W-1:0] rank_sum
);

    import erm_pkg::*;

    logic             less;
    logic [CNT_W-1:0] rank_reg;
    logic [CNT_W-1:0] rank_next;

    // Stable ordering: equal keys rank by slot index
    assign less = (key_j < cand) || ((key_j == cand) && (idx_j < idx_i));
    assign rank_sum = rank_reg + CNT_W'(less);

    always_comb
    begin
        rank_next = rank_reg;
        if (ctl.clear)
        begin
            rank_next = '0;
        end
        else if (ctl.step)
        begin
            rank_next = rank_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

endmodule

// File: rtl/echo_range_median_filter.sv
// Echo range median filter. Each beat on the input carries one echo width
// in microseconds; it is scaled to 1/16 cm, range checked, written into a
// five-entry ring, and one result beat returns the upper median of the
// entries filled so far (invalid readings sort last). The block takes one
// item at a time and holds in_stall high while it works. A single comparator
// ranks each candidate against every filled entry (1 to 5 of them), read
// one per cycle from the ring RAM; candidates are tried in slot order until
// the median is found, and the result may then wait for the output register
// to drain. Configuration writes are taken any time.
module echo_range_median_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [erm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [erm_pkg::DIST_W-1:0]    cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [erm_pkg::WIDTH_W-1:0]   echo_width_us,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [erm_pkg::DIST_W-1:0]    median_distance,
    output logic                          median_valid,
    output logic                          raw_valid
);

    import erm_pkg::*;

    state_t state_reg, state_next;

    // Configuration registers
    logic [DIST_W-1:0] min_range_reg;
    logic [DIST_W-1:0] max_range_reg;

    // Item datapath
    logic [WIDTH_W-1:0] width_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [PROD_W-1:0]  prod;
    logic               ok;
    logic               raw_ok_reg, raw_ok_next;

    // Ring bookkeeping
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              full_reg, full_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  slot_inc;
    logic              slot_wrap;

    // Rank search
    logic [SLOT_W-1:0] cand_idx_reg, cand_idx_next;
    logic [SLOT_W-1:0] j_reg, j_next;
    logic [KEY_W-1:0]  cand_reg, cand_next;
    logic [KEY_W-1:0]  rd_key;
    logic [CNT_W-1:0]  rank_sum;
    logic              j_last;
    logic              found;
    rank_ctl_t         rank_ctl;

    // RAM ports
    logic              ram_we;
    logic [SLOT_W-1:0] ram_raddr;
    logic [KEY_W-1:0]  ram_wdata;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] med_dist_reg, med_dist_next;
    logic              med_ok_reg, med_ok_next;
    logic              raw_out_reg, raw_out_next;
    logic              out_free;

    logic in_beat;

    assign in_beat  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Scale and range check
    assign prod = PROD_W'(width_reg) * PROD_W'(DIST_SCALE);
    assign ok   = (width_reg != '0) && (dist_reg >= min_range_reg)
                  && (dist_reg <= max_range_reg);
    assign ram_wdata = ok ? {1'b0, dist_reg} : KEY_INVALID;

    // Ring slot advance
    assign slot_inc  = CNT_W'(slot_reg) + CNT_W'(1);
    assign slot_wrap = (slot_inc == CNT_W'(WINDOW));

    // Search bookkeeping
    assign j_last = (CNT_W'(j_reg) == (count_reg - CNT_W'(1)));
    assign found  = (state_reg == ST_CMP) && j_last && (rank_sum == (count_reg >> 1));

    erm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_key)
    );

    erm_rank u_rank (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rank_ctl),
        .key_j    (rd_key),
        .cand     (cand_reg),
        .idx_j    (j_reg),
        .idx_i    (cand_idx_reg),
        .rank_sum (rank_sum)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:     state_next = ST_WRITE;
            ST_WRITE:   state_next = ST_RD_CAND;
            ST_RD_CAND: state_next = ST_LD_CAND;
            ST_LD_CAND: state_next = ST_CMP;
            ST_CMP:
            begin
                if (found)
                begin
                    state_next = ST_DONE;
                end
                else if (j_last)
                begin
                    state_next = ST_RD_CAND;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath control and register next values
    always_comb
    begin
        in_stall       = (state_reg != ST_IDLE);
        ram_we         = 1'b0;
        ram_raddr      = cand_idx_reg;
        rank_ctl       = '0;
        raw_ok_next    = raw_ok_reg;
        slot_next      = slot_reg;
        full_next      = full_reg;
        count_next     = count_reg;
        cand_idx_next  = cand_idx_reg;
        j_next         = j_reg;
        cand_next      = cand_reg;
        out_valid_next = out_valid_reg && out_stall;
        med_dist_next  = med_dist_reg;
        med_ok_next    = med_ok_reg;
        raw_out_next   = raw_out_reg;
        unique case (state_reg)
            ST_WRITE:
            begin
                ram_we        = 1'b1;
                raw_ok_next   = ok;
                slot_next     = slot_wrap ? '0 : SLOT_W'(slot_inc);
                full_next     = full_reg || slot_wrap;
                count_next    = (full_reg || slot_wrap) ? CNT_W'(WINDOW) : slot_inc;
                cand_idx_next = '0;
            end
            ST_RD_CAND:
            begin
                ram_raddr = cand_idx_reg;
            end
            ST_LD_CAND:
            begin
                // candidate key arrives; start reading entry 0
                cand_next     = rd_key;
                ram_raddr     = '0;
                j_next        = '0;
                rank_ctl.clear = 1'b1;
            end
            ST_CMP:
            begin
                ram_raddr     = SLOT_W'(CNT_W'(j_reg) + CNT_W'(1));
                rank_ctl.step = 1'b1;
                j_next        = SLOT_W'(CNT_W'(j_reg) + CNT_W'(1));
                if (j_last)
                begin
                    cand_idx_next = SLOT_W'(CNT_W'(cand_idx_reg) + CNT_W'(1));
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    med_ok_next    = !cand_reg[KEY_W-1];
                    med_dist_next  = cand_reg[KEY_W-1] ? '0 : cand_reg[DIST_W-1:0];
                    raw_out_next   = raw_ok_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_range_reg <= MIN_RANGE_RST;
            max_range_reg <= MAX_RANGE_RST;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            count_reg     <= '0;
            cand_idx_reg  <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            full_reg      <= full_next;
            count_reg     <= count_next;
            cand_idx_reg  <= cand_idx_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MIN_RANGE: min_range_reg <= cfg_data;
                    REG_MAX_RANGE: max_range_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            width_reg <= echo_width_us;
        end
        if (state_reg == ST_MUL)
        begin
            dist_reg <= prod[DIST_SHIFT +: DIST_W];
        end
        raw_ok_reg   <= raw_ok_next;
        cand_reg     <= cand_next;
        med_dist_reg <= med_dist_next;
        med_ok_reg   <= med_ok_next;
        raw_out_reg  <= raw_out_next;
    end

    assign out_valid       = out_valid_reg;
    assign median_distance = med_dist_reg;
    assign median_valid    = med_ok_reg;
    assign raw_valid       = raw_out_reg;

endmodule

// File: rtl/erm_checker.sv
`include "assert_macros.svh"

module erm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [erm_pkg::DIST_W-1:0]    median_distance,
    input logic                          median_valid
);

    import erm_pkg::*;

    // An input beat that is taken makes the block busy
    `CHK_ASSERT(a_busy_after_beat, (in_valid && !in_stall) |=> in_stall, "not busy after input beat")

    // A new result only comes out of a busy block
    `CHK_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result without work")

    // Invalid median reports zero distance
    `CHK_ALWAYS(a_invalid_zero, !(out_valid && !median_valid && (median_distance != '0)), "invalid median with nonzero distance")

    // Stalled result holds
    `CHK_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(median_distance)), "stalled result changed")

endmodule

bind echo_range_median_filter erm_checker u_erm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .median_distance (median_distance),
    .median_valid    (median_valid)
);
